/* rtl/core/interpolating_lookup_table_defines.svh */
// assertion macros for the interpolating lookup table
// used by the rtl modules that carry concurrent checks
`ifndef INTERPOLATING_LOOKUP_TABLE_DEFINES_SVH
`define INTERPOLATING_LOOKUP_TABLE_DEFINES_SVH

// same-cycle implication
`define ILT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ILT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ilt_pkg.sv */
// shared types and constants of the interpolating lookup table
// no dependencies
`default_nettype none

package ilt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SIZE_W      = 7;
  localparam int ENTRY_IDX_W = 6;
  localparam int DATA_W      = 32;
  localparam int GAUSS_W     = 16;
  localparam int FRAC_W      = 16;
  localparam int ENTRY_W     = 3 * DATA_W;

  localparam logic signed [48:0] ONE_Q28 = 49'sd268435456;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] n;
  } entry_t;

  typedef struct packed {
    logic                      op;
    logic [ENTRY_IDX_W-1:0]    entry_index;
    logic signed [DATA_W-1:0]  entry_input;
    logic signed [DATA_W-1:0]  entry_output;
    logic signed [DATA_W-1:0]  entry_noise;
    logic signed [DATA_W-1:0]  query_value;
    logic signed [GAUSS_W-1:0] gauss_sample;
  } in_item_t;

  typedef enum logic [4:0] {
    CMD_IDLE, CMD_RD0, CMD_CK0, CMD_RDL, CMD_CKL, CMD_SRD, CMD_SCK, CMD_PREP,
    CMD_DIV, CMD_LY, CMD_LN, CMD_NZ, CMD_FAC, CMD_SH, CMD_SL, CMD_SUM, CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic in_fire;
  } cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic n_zero;
    logic q_le_x;
    logic q_ge_x;
    logic more;
    logic t_fixed;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/ilt_intf.sv */
// handshake channels of the interpolating lookup table
// depends on ilt_pkg
`default_nettype none

interface ilt_in_if;
  import ilt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [ENTRY_IDX_W-1:0]    entry_index;
  logic signed [DATA_W-1:0]  entry_input;
  logic signed [DATA_W-1:0]  entry_output;
  logic signed [DATA_W-1:0]  entry_noise;
  logic signed [DATA_W-1:0]  query_value;
  logic signed [GAUSS_W-1:0] gauss_sample;

  modport source (output valid, op, entry_index, entry_input, entry_output, entry_noise,
                  query_value, gauss_sample, input ready);
  modport sink (input valid, op, entry_index, entry_input, entry_output, entry_noise,
                query_value, gauss_sample, output ready);
endinterface

interface ilt_out_if;
  import ilt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     saturated;

  modport source (output valid, result_value, saturated, input ready);
  modport sink (input valid, result_value, saturated, output ready);
endinterface

`default_nettype wire

/* rtl/core/interpolating_lookup_table.sv */
// A lookup with an empty table goes straight to output; one at or below the low end or
// at or above the high end takes the end entry, and otherwise it runs a binary search of
// k <= ceil(log2(n - 1)) steps through the registered-read ram, then uses a fixed fraction
// or the 16-step divider.
// Throughput: one item at a time; the next item is taken when the lookup has moved its
// result to the output register. Reset clears the sequencer, output valid and table size.
`default_nettype none

module interpolating_lookup_table (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ilt_pkg::SIZE_W-1:0] cfg_wdata_i,
  ilt_in_if.sink                          in_i,
  ilt_out_if.source                       out_o
);
  import ilt_pkg::*;

  cmd_t     cmd;
  status_t  status;
  in_item_t item;
  logic     in_ready;

  // gather the input payload
  assign item.op           = in_i.op;
  assign item.entry_index  = in_i.entry_index;
  assign item.entry_input  = in_i.entry_input;
  assign item.entry_output = in_i.entry_output;
  assign item.entry_noise  = in_i.entry_noise;
  assign item.query_value  = in_i.query_value;
  assign item.gauss_sample = in_i.gauss_sample;
  assign in_i.ready        = in_ready;

  ilt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ilt_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_ready_i    (out_o.ready),
    .status_o       (status),
    .out_valid_o    (out_o.valid),
    .result_value_o (out_o.result_value),
    .saturated_o    (out_o.saturated)
  );

endmodule

`default_nettype wire

/* rtl/core/ilt_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module ilt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/ilt_ctrl.sv */
// sequencer of the interpolating lookup table
// depends on ilt_pkg; drives commands into ilt_datapath
`default_nettype none

module ilt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ilt_pkg::status_t status_i,
  output ilt_pkg::cmd_t        cmd_o
);
  import ilt_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001, S_RD0 = 17'h00002, S_CK0 = 17'h00004, S_RDL = 17'h00008,
    S_CKL  = 17'h00010, S_SRD = 17'h00020, S_SCK = 17'h00040, S_PREP = 17'h00080,
    S_DIV  = 17'h00100, S_LY  = 17'h00200, S_LN  = 17'h00400, S_NZ  = 17'h00800,
    S_FAC  = 17'h01000, S_SH  = 17'h02000, S_SL  = 17'h04000, S_SUM = 17'h08000,
    S_OUT  = 17'h10000
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign fire       = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (fire && status_i.is_lookup) begin
          state_d = status_i.n_zero ? S_OUT : S_RD0;
        end
      end
      S_RD0:  state_d = S_CK0;
      S_CK0:  state_d = status_i.q_le_x ? S_LY : S_RDL;
      S_RDL:  state_d = S_CKL;
      S_CKL:  state_d = status_i.q_ge_x ? S_LY : S_SRD;
      S_SRD:  state_d = status_i.more ? S_SCK : S_PREP;
      S_SCK:  state_d = S_SRD;
      S_PREP: state_d = status_i.t_fixed ? S_LY : S_DIV;
      S_DIV:  state_d = status_i.div_done ? S_LY : S_DIV;
      S_LY:   state_d = S_LN;
      S_LN:   state_d = S_NZ;
      S_NZ:   state_d = S_FAC;
      S_FAC:  state_d = S_SH;
      S_SH:   state_d = S_SL;
      S_SL:   state_d = S_SUM;
      S_SUM:  state_d = S_OUT;
      S_OUT:  state_d = status_i.out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd_o.in_fire = fire;
    unique case (state_q)
      S_IDLE:  cmd_o.op = CMD_IDLE;
      S_RD0:   cmd_o.op = CMD_RD0;
      S_CK0:   cmd_o.op = CMD_CK0;
      S_RDL:   cmd_o.op = CMD_RDL;
      S_CKL:   cmd_o.op = CMD_CKL;
      S_SRD:   cmd_o.op = CMD_SRD;
      S_SCK:   cmd_o.op = CMD_SCK;
      S_PREP:  cmd_o.op = CMD_PREP;
      S_DIV:   cmd_o.op = CMD_DIV;
      S_LY:    cmd_o.op = CMD_LY;
      S_LN:    cmd_o.op = CMD_LN;
      S_NZ:    cmd_o.op = CMD_NZ;
      S_FAC:   cmd_o.op = CMD_FAC;
      S_SH:    cmd_o.op = CMD_SH;
      S_SL:    cmd_o.op = CMD_SL;
      S_SUM:   cmd_o.op = CMD_SUM;
      S_OUT:   cmd_o.op = CMD_OUT;
      default: cmd_o.op = CMD_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ilt_datapath.sv */
// table storage, search, divider, interpolation and noise scaling
// depends on ilt_pkg, ilt_ram and the assertion macro header
`default_nettype none
`include "interpolating_lookup_table_defines.svh"

module ilt_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ilt_pkg::cmd_t                   cmd_i,
  input  wire ilt_pkg::in_item_t               item_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [ilt_pkg::SIZE_W-1:0]      cfg_wdata_i,
  input  wire logic                            out_ready_i,
  output ilt_pkg::status_t                     status_o,
  output logic                                 out_valid_o,
  output logic signed [ilt_pkg::DATA_W-1:0]    result_value_o,
  output logic                                 saturated_o
);
  import ilt_pkg::*;

  // registers
  logic [CNT_W-1:0]          n_q;
  logic signed [DATA_W-1:0]  q_q;
  logic signed [GAUSS_W-1:0] g_q;
  entry_t                    e_lo_q, e_hi_q;
  logic [IDX_W-1:0]          lo_q, hi_q, mid_q;
  logic [FRAC_W:0]           t_q;
  logic [DATA_W:0]           rem_q, den_q;
  logic [4:0]                cnt_q;
  logic signed [50:0]        prod_q;
  logic signed [DATA_W-1:0]  y_q, nz_q;
  logic signed [48:0]        fac_q;
  logic signed [56:0]        a_q, b_q;
  logic signed [DATA_W-1:0]  res_q, out_res_q;
  logic                      sat_q, out_sat_q, out_valid_q;

  // combinational nets
  logic [IDX_W-1:0]          last, raddr, mid_d;
  logic [ENTRY_W-1:0]        rdata;
  entry_t                    rd;
  logic                      we;
  logic signed [DATA_W:0]    num_s, den_s;
  logic [DATA_W+1:0]         sh;
  logic                      ge;
  logic signed [DATA_W:0]    dif;
  logic signed [FRAC_W+1:0]  tt;
  logic signed [50:0]        prod_d;
  logic signed [DATA_W-1:0]  lerp_sum;
  logic signed [47:0]        ng;
  logic signed [24:0]        mop;
  logic signed [56:0]        sp;
  logic signed [81:0]        full;
  logic [53:0]               r;
  logic                      ovf, out_free;
  logic [CNT_W-1:0]          n_d;
  logic [CNT_W:0]            lo_inc;

  assign rd       = entry_t'(rdata);
  assign last     = IDX_W'(n_q - CNT_W'(1));
  assign mid_d    = IDX_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign out_free = !out_valid_q || out_ready_i;
  assign we       = cmd_i.op == CMD_IDLE && cmd_i.in_fire && item_i.op == OP_WRITE
                    && int'(item_i.entry_index) < TABLE_DEPTH;

  // table read address
  always_comb begin
    case (cmd_i.op)
      CMD_RDL: raddr = last;
      CMD_SRD: raddr = mid_d;
      default: raddr = '0;
    endcase
  end

  ilt_ram #(.Width(ENTRY_W), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (IDX_W'(item_i.entry_index)),
    .wdata_i ({item_i.entry_input, item_i.entry_output, item_i.entry_noise}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // fraction setup and divider step
  always_comb begin
    num_s = {q_q[DATA_W-1], q_q} - {e_lo_q.x[DATA_W-1], e_lo_q.x};
    den_s = {e_hi_q.x[DATA_W-1], e_hi_q.x} - {e_lo_q.x[DATA_W-1], e_lo_q.x};
    sh    = {rem_q, 1'b0};
    ge    = sh >= {1'b0, den_q};
  end

  // shared interpolation multiplier and adder
  always_comb begin
    if (cmd_i.op == CMD_LN) begin
      dif = {e_hi_q.n[DATA_W-1], e_hi_q.n} - {e_lo_q.n[DATA_W-1], e_lo_q.n};
    end else begin
      dif = {e_hi_q.y[DATA_W-1], e_hi_q.y} - {e_lo_q.y[DATA_W-1], e_lo_q.y};
    end
    tt       = {1'b0, t_q};
    prod_d   = dif * tt;
    lerp_sum = ((cmd_i.op == CMD_NZ) ? e_lo_q.n : e_lo_q.y) + prod_q[47:16];
  end

  // noise factor and split scaling multiplier
  always_comb begin
    ng = nz_q * g_q;
    if (cmd_i.op == CMD_SL) begin
      mop = {1'b0, fac_q[23:0]};
    end else begin
      mop = fac_q[48:24];
    end
    sp   = y_q * mop;
    full = {{a_q[56]}, a_q, 24'd0} + {{25{b_q[56]}}, b_q};
    r    = full[81:28];
    ovf  = !((&r[53:31]) || !(|r[53:31]));
  end

  // table size clamp
  always_comb begin
    if (int'(cfg_wdata_i) > TABLE_DEPTH) begin
      n_d = CNT_W'(TABLE_DEPTH);
    end else begin
      n_d = CNT_W'(cfg_wdata_i);
    end
  end

  // status to the sequencer
  always_comb begin
    lo_inc            = {2'b0, lo_q} + (CNT_W + 1)'(1);
    status_o.is_lookup = item_i.op == OP_LOOKUP;
    status_o.n_zero    = n_q == '0;
    status_o.q_le_x    = q_q <= rd.x;
    status_o.q_ge_x    = q_q >= rd.x;
    status_o.more      = lo_inc < {2'b0, hi_q};
    status_o.t_fixed   = den_s <= 0 || num_s <= 0 || num_s >= den_s;
    status_o.div_done  = cnt_q == 5'd15;
    status_o.out_free  = out_free;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        n_q <= n_d;
      end
      if (cmd_i.op == CMD_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_IDLE: begin
        if (cmd_i.in_fire) begin
          q_q   <= item_i.query_value;
          g_q   <= item_i.gauss_sample;
          res_q <= item_i.query_value;
          sat_q <= 1'b0;
        end
      end
      CMD_CK0: begin
        e_lo_q <= rd;
        if (q_q <= rd.x) begin
          e_hi_q <= rd;
          t_q    <= '0;
        end
      end
      CMD_CKL: begin
        e_hi_q <= rd;
        lo_q   <= '0;
        hi_q   <= last;
        t_q    <= {1'b1, {FRAC_W{1'b0}}};
      end
      CMD_SRD: mid_q <= mid_d;
      CMD_SCK: begin
        if (q_q < rd.x) begin
          hi_q   <= mid_q;
          e_hi_q <= rd;
        end else begin
          lo_q   <= mid_q;
          e_lo_q <= rd;
        end
      end
      CMD_PREP: begin
        cnt_q <= '0;
        rem_q <= num_s[DATA_W:0];
        den_q <= den_s[DATA_W:0];
        if (den_s <= 0 || num_s <= 0) begin
          t_q <= '0;
        end else if (num_s >= den_s) begin
          t_q <= {1'b1, {FRAC_W{1'b0}}};
        end else begin
          t_q <= '0;
        end
      end
      CMD_DIV: begin
        cnt_q <= cnt_q + 5'd1;
        if (ge) begin
          rem_q <= DATA_W'(sh - {1'b0, den_q}) + (DATA_W + 1)'(0);
          t_q   <= {t_q[FRAC_W-1:0], 1'b1};
        end else begin
          rem_q <= sh[DATA_W:0];
          t_q   <= {t_q[FRAC_W-1:0], 1'b0};
        end
      end
      CMD_LY:  prod_q <= prod_d;
      CMD_LN: begin
        y_q    <= lerp_sum;
        prod_q <= prod_d;
      end
      CMD_NZ:  nz_q  <= lerp_sum;
      CMD_FAC: fac_q <= ONE_Q28 + {ng[47], ng};
      CMD_SH:  a_q   <= sp;
      CMD_SL:  b_q   <= sp;
      CMD_SUM: begin
        sat_q <= ovf;
        if (ovf) begin
          res_q <= r[53] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
          res_q <= r[DATA_W-1:0];
        end
      end
      CMD_OUT: begin
        if (out_free) begin
          out_res_q <= res_q;
          out_sat_q <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign saturated_o    = out_sat_q;

  `ILT_ASSERT_IMP(a_search_order, clk_i, rst_ni, cmd_i.op == CMD_SCK, lo_q < hi_q, "search bounds crossed")
  `ILT_ASSERT_IMP(a_div_rem, clk_i, rst_ni, cmd_i.op == CMD_DIV, rem_q < den_q, "divider remainder out of range")
  `ILT_ASSERT_NXT(a_out_load, clk_i, rst_ni, cmd_i.op == CMD_OUT && out_free, out_valid_q, "result not loaded")

endmodule

`default_nettype wire

/* tb/sv/tb_interpolating_lookup_table.sv */
// testbench for the interpolating lookup table: directed rows, then random phases with idling
// depends on ilt_pkg, ilt_in_if, ilt_out_if and interpolating_lookup_table
`timescale 1ns / 100ps
`default_nettype none

module tb_interpolating_lookup_table;
  import ilt_pkg::*;

  localparam int  HALF_PERIOD = 5;
  localparam int  CYCLE_LIMIT = 600000;
  localparam int  DRAIN_WAIT  = 50;
  localparam int  HOLD_CYCLES = 400;
  localparam int  MIXED_ITEMS = 180;
  localparam int  NO_SIZE     = -1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } result_t;

  typedef struct {
    op_e                       op;
    logic [ENTRY_IDX_W-1:0]    idx;
    logic signed [DATA_W-1:0]  x;
    logic signed [DATA_W-1:0]  y;
    logic signed [DATA_W-1:0]  n;
    logic signed [DATA_W-1:0]  q;
    logic signed [GAUSS_W-1:0] g;
    int                        set_size;
    bit                        typed;
    result_t                   want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;

  ilt_in_if  in_ch ();
  ilt_out_if out_ch ();

  interpolating_lookup_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // clock
  always #HALF_PERIOD clk_i = ~clk_i;

  // predictor state
  logic signed [DATA_W-1:0] bp_x [TABLE_DEPTH];
  logic signed [DATA_W-1:0] bp_y [TABLE_DEPTH];
  logic signed [DATA_W-1:0] bp_n [TABLE_DEPTH];
  int      tbl_size;
  result_t pending_results [$];

  int errors = 0;
  int cycles = 0;
  int n_writes = 0;
  int n_lookups = 0;
  int n_sat = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  dir_row_t dir_rows [14] = '{
    '{OP_LOOKUP, 6'd0, 32'sd0, 32'sd0, 32'sd0, 32'h7fffffff, 16'sd0, NO_SIZE, 1'b1,
      '{32'h7fffffff, 1'b0}},
    '{OP_LOOKUP, 6'd0, 32'sd0, 32'sd0, 32'sd0, 32'h80000000, 16'h7fff, NO_SIZE, 1'b1,
      '{32'h80000000, 1'b0}},
    '{OP_LOOKUP, 6'd63, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'h8000, NO_SIZE, 1'b1,
      '{32'sd0, 1'b0}},
    '{OP_WRITE, 6'd0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'sd0, 16'sd0, NO_SIZE,
      1'b0, '{32'sd0, 1'b0}},
    '{OP_WRITE, 6'd1, -32'sh10000, 32'h80000000, 32'h80000000, 32'sd0, 16'sd0, NO_SIZE,
      1'b0, '{32'sd0, 1'b0}},
    '{OP_WRITE, 6'd2, 32'sh10000, 32'sd0, 32'sd0, 32'sd0, 16'sd0, NO_SIZE,
      1'b0, '{32'sd0, 1'b0}},
    '{OP_WRITE, 6'd3, 32'h7fffffff, 32'h12345678, 32'sh1000, 32'sd0, 16'sd0, NO_SIZE,
      1'b0, '{32'sd0, 1'b0}},
    // low end with huge noise saturates both ways
    '{OP_LOOKUP, 6'd0, 32'sd0, 32'sd0, 32'sd0, 32'h80000000, 16'h7fff, 4, 1'b1,
      '{32'h7fffffff, 1'b1}},
    '{OP_LOOKUP, 6'd0, 32'sd0, 32'sd0, 32'sd0, 32'h80000000, 16'h8000, NO_SIZE, 1'b1,
      '{32'h80000000, 1'b1}},
    // high end with zero gaussian keeps the output
    '{OP_LOOKUP, 6'd0, 32'sd0, 32'sd0, 32'sd0, 32'h7fffffff, 16'sd0, NO_SIZE, 1'b1,
      '{32'h12345678, 1'b0}},
    // interior points
    '{OP_LOOKUP, 6'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sh1000, NO_SIZE, 1'b0,
      '{32'sd0, 1'b0}},
    '{OP_LOOKUP, 6'd0, 32'sd0, 32'sd0, 32'sd0, -32'sh8000, 16'sh0123, NO_SIZE, 1'b0,
      '{32'sd0, 1'b0}},
    '{OP_LOOKUP, 6'd0, 32'sd0, 32'sd0, 32'sd0, 32'sh10000, 16'h8000, NO_SIZE, 1'b0,
      '{32'sd0, 1'b0}},
    // interior point just above zero
    '{OP_LOOKUP, 6'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd5, 16'sd7, NO_SIZE, 1'b0,
      '{32'sd0, 1'b0}}
  };

  // expected result of one lookup under the current table
  function automatic result_t lookup_result(logic signed [DATA_W-1:0] q,
                                            logic signed [GAUSS_W-1:0] g);
    result_t res;
    int n, last, lo, hi, mid;
    longint y, nz, num, den, t, f;
    logic signed [127:0] yw, fw, r;
    n = (tbl_size > TABLE_DEPTH) ? TABLE_DEPTH : tbl_size;
    if (n == 0) begin
      res.value = q;
      res.sat = 1'b0;
      return res;
    end
    last = n - 1;
    if (q <= bp_x[0]) begin
      y = bp_y[0];
      nz = bp_n[0];
    end else if (q >= bp_x[last]) begin
      y = bp_y[last];
      nz = bp_n[last];
    end else begin
      lo = 0;
      hi = last;
      mid = last / 2;
      while (lo + 1 < hi) begin
        if (q < bp_x[mid]) hi = mid;
        else lo = mid;
        mid = (lo + hi) / 2;
      end
      num = longint'(q) - longint'(bp_x[lo]);
      den = longint'(bp_x[hi]) - longint'(bp_x[lo]);
      if (den <= 0 || num <= 0) t = 0;
      else if (num >= den) t = 65536;
      else t = (num * 65536) / den;
      y = longint'(bp_y[lo]) + (((longint'(bp_y[hi]) - longint'(bp_y[lo])) * t) >>> 16);
      nz = longint'(bp_n[lo]) + (((longint'(bp_n[hi]) - longint'(bp_n[lo])) * t) >>> 16);
    end
    // multiplicative noise, floor of the Q.28 product
    if (nz != 0) begin
      f = 268435456 + nz * longint'(g);
      yw = y;
      fw = f;
      r = (yw * fw) >>> 28;
    end else begin
      r = y;
    end
    res.sat = 1'b0;
    if (r > 128'sd2147483647) begin
      r = 128'sd2147483647;
      res.sat = 1'b1;
    end else if (r < -128'sd2147483648) begin
      r = -128'sd2147483648;
      res.sat = 1'b1;
    end
    res.value = r[DATA_W-1:0];
    return res;
  endfunction

  // offer one item, with idle cycles before it, and record its effect on acceptance
  task automatic send_item(in_item_t it, bit typed, result_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        = 1'b1;
    in_ch.op           = it.op;
    in_ch.entry_index  = it.entry_index;
    in_ch.entry_input  = it.entry_input;
    in_ch.entry_output = it.entry_output;
    in_ch.entry_noise  = it.entry_noise;
    in_ch.query_value  = it.query_value;
    in_ch.gauss_sample = it.gauss_sample;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (it.op == OP_WRITE) begin
      bp_x[it.entry_index] = it.entry_input;
      bp_y[it.entry_index] = it.entry_output;
      bp_n[it.entry_index] = it.entry_noise;
      n_writes++;
    end else begin
      pending_results.push_back(typed ? want : lookup_result(it.query_value, it.gauss_sample));
      n_lookups++;
    end
    @(negedge clk_i);
  endtask

  // table size is written only once the block has drained
  task automatic set_table_size(int size);
    in_ch.valid = 1'b0;
    @(negedge clk_i);
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = SIZE_W'(size);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tbl_size = size & 7'h7f;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_noise();
    case ($urandom_range(3))
      0: return '0;
      1: return $signed($urandom) >>> 18;
      2: return $signed($urandom);
      default: return $signed($urandom) >>> 10;
    endcase
  endfunction

  function automatic in_item_t write_item(int k, bit sorted);
    in_item_t it;
    it = '0;
    it.op = OP_WRITE;
    it.entry_index = ENTRY_IDX_W'(k);
    it.entry_input = sorted ? DATA_W'(-64'sd2147483648 + longint'(k) * 64'sd67108864
                                      + longint'($urandom_range(0, 67108863)))
                            : $signed($urandom);
    it.entry_output = $urandom_range(3) == 0 ? $signed($urandom) : $signed($urandom) >>> 8;
    it.entry_noise = pick_noise();
    it.query_value = $urandom;
    it.gauss_sample = GAUSS_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t lookup_item();
    in_item_t it;
    int k;
    it = '0;
    it.op = OP_LOOKUP;
    it.entry_index = ENTRY_IDX_W'($urandom);
    it.entry_input = $urandom;
    it.entry_output = $urandom;
    it.entry_noise = $urandom;
    it.gauss_sample = GAUSS_W'($urandom);
    k = $urandom_range(TABLE_DEPTH - 1);
    case ($urandom_range(9))
      0, 1: it.query_value = $urandom;
      2: it.query_value = bp_x[k];
      default: it.query_value = bp_x[k] + ($signed($urandom) >>> 6);
    endcase
    return it;
  endfunction

  // receiver: random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no lookup pending: value %h", out_ch.result_value);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (out_ch.result_value !== w.value) begin
          $error("result_value expected %h actual %h", w.value, out_ch.result_value);
          errors++;
        end
        if (out_ch.saturated !== w.sat) begin
          $error("saturated expected %b actual %b", w.sat, out_ch.saturated);
          errors++;
        end
        if (out_ch.saturated) n_sat++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_interpolating_lookup_table: FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    int size_plan [5] = '{64, 1, 2, 127, 23};
    int idle_plan [5] = '{0, 58, 0, 35, 0};
    int stall_plan [5] = '{0, 0, 58, 35, 0};
    in_item_t it;
    result_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_input = '0;
    in_ch.entry_output = '0;
    in_ch.entry_noise = '0;
    in_ch.query_value = '0;
    in_ch.gauss_sample = '0;
    out_ch.ready = 1'b0;
    tbl_size = 0;
    foreach (bp_x[k]) begin
      bp_x[k] = '0;
      bp_y[k] = '0;
      bp_n[k] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows
    foreach (dir_rows[r]) begin
      if (dir_rows[r].set_size != NO_SIZE) set_table_size(dir_rows[r].set_size);
      it = '0;
      it.op = dir_rows[r].op;
      it.entry_index = dir_rows[r].idx;
      it.entry_input = dir_rows[r].x;
      it.entry_output = dir_rows[r].y;
      it.entry_noise = dir_rows[r].n;
      it.query_value = dir_rows[r].q;
      it.gauss_sample = dir_rows[r].g;
      send_item(it, dir_rows[r].typed, dir_rows[r].want);
    end

    // random phases: refill the table, set a size, then mixed traffic
    for (int p = 0; p < 5; p++) begin
      idle_pct = idle_plan[p];
      stall_pct = stall_plan[p];
      for (int k = 0; k < TABLE_DEPTH; k++) send_item(write_item(k, p != 3), 1'b0, none);
      set_table_size(size_plan[p]);
      if (p == 4) hold_reqs++;
      for (int i = 0; i < MIXED_ITEMS; i++) begin
        if ($urandom_range(4) == 0)
          send_item(write_item($urandom_range(TABLE_DEPTH - 1), 1'b0), 1'b0, none);
        else
          send_item(lookup_item(), 1'b0, none);
      end
    end
    set_table_size(0);
    for (int i = 0; i < 20; i++) send_item(lookup_item(), 1'b0, none);

    // drain
    in_ch.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("covered %0d writes and %0d lookups (%0d saturated) over table sizes 0 to 127",
             n_writes, n_lookups, n_sat);
    $display("with sender gaps, receiver stalls and a long output hold-off");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_interpolating_lookup_table: PASS");
    end else begin
      $display("tb_interpolating_lookup_table: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
